// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the collision block checks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== hdl/ccpv_pkg.sv =====
// ---------------------------------------------------------------------------
// ccpv_pkg
// Types and widths for the circle collision push vector block.
// ---------------------------------------------------------------------------
package ccpv_pkg;

    localparam int COORD_W   = 24;  // Q16.8 positions
    localparam int FRAC_BITS = 8;
    localparam int RAD_W     = 23;
    localparam int DIR_W     = 16;  // Q2.14 direction
    localparam int OFS_W     = COORD_W + 1;
    localparam int SQ_W      = 2 * OFS_W;
    localparam int L2_W      = 2 * DIR_W;
    localparam int OP_W      = 58;  // square root operand
    localparam int ROOT_W    = OP_W / 2 - 0;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int DEP_W     = 31;
    localparam int PROD_W    = OFS_W + DEP_W;
    localparam int NUM_W     = 54;
    localparam int QUO_W     = 27;
    localparam int DREM_W    = ROOT_W;
    localparam int LATENCY   = 7 + ROOT_W + QUO_W;

    typedef struct packed {
        logic                       func;
        logic signed [COORD_W-1:0]  circle_x;
        logic signed [COORD_W-1:0]  circle_y;
        logic        [RAD_W-1:0]    circle_radius;
        logic signed [COORD_W-1:0]  shape_a;
        logic signed [COORD_W-1:0]  shape_b;
        logic signed [COORD_W-1:0]  shape_c;
        logic signed [COORD_W-1:0]  shape_d;
        logic signed [DIR_W-1:0]    last_dir_x;
        logic signed [DIR_W-1:0]    last_dir_y;
    } item_t;

    typedef struct packed {
        logic                       hit;
        logic signed [COORD_W-1:0]  push_x;
        logic signed [COORD_W-1:0]  push_y;
    } result_t;

    // carried alongside the square root
    typedef struct packed {
        logic                       func;
        logic        [RAD_W-1:0]    rad;
        logic signed [OFS_W-1:0]    ox;
        logic signed [OFS_W-1:0]    oy;
        logic signed [DIR_W-1:0]    lx;
        logic signed [DIR_W-1:0]    ly;
        logic signed [OFS_W-1:0]    sum;
        logic                       zero;
        logic                       chit;
    } sqrt_tag_t;

    // carried alongside the divider
    typedef struct packed {
        logic hit;
        logic zpush;
        logic neg_x;
        logic neg_y;
    } div_tag_t;

endpackage

// ===== hdl/ccpv_sqrt.sv =====
// ---------------------------------------------------------------------------
// ccpv_sqrt
// Pipelined integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
module ccpv_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [ccpv_pkg::OP_W-1:0]     operand,
    input  ccpv_pkg::sqrt_tag_t           tag,
    output logic                          done,
    output logic [ccpv_pkg::ROOT_W-1:0]   root,
    output ccpv_pkg::sqrt_tag_t           result_tag
);

    localparam int STEPS = ccpv_pkg::ROOT_W;
    localparam int OPW   = ccpv_pkg::OP_W;
    localparam int RW    = ccpv_pkg::SREM_W;

    logic [STEPS:0]                  valid_reg;
    logic [OPW-1:0]                  op_reg   [0:STEPS];
    logic [RW-1:0]                   rem_reg  [0:STEPS];
    logic [STEPS-1:0]                root_reg [0:STEPS];
    ccpv_pkg::sqrt_tag_t             tag_reg  [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STEPS-1:0], load};
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg[0]   <= operand;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        tag_reg[0]  <= tag;
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [RW-1:0]    acc;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    rem_next;
        logic [STEPS-1:0] root_next;

        always_comb
        begin
            acc   = {rem_reg[k][RW-3:0], op_reg[k][OPW-1-2*k -: 2]};
            trial = {root_reg[k], 2'b01};
            if (acc >= trial)
            begin
                rem_next  = acc - trial;
                root_next = {root_reg[k][STEPS-2:0], 1'b1};
            end
            else
            begin
                rem_next  = acc;
                root_next = {root_reg[k][STEPS-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            op_reg[k+1]   <= op_reg[k];
            rem_reg[k+1]  <= rem_next;
            root_reg[k+1] <= root_next;
            tag_reg[k+1]  <= tag_reg[k];
        end
    end

    assign done       = valid_reg[STEPS];
    assign root       = root_reg[STEPS];
    assign result_tag = tag_reg[STEPS];

endmodule

// ===== hdl/ccpv_div.sv =====
// ---------------------------------------------------------------------------
// ccpv_div
// Pipelined restoring divider, two numerators over one shared divisor.
// ---------------------------------------------------------------------------
module ccpv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [ccpv_pkg::NUM_W-1:0]    num_x,
    input  logic [ccpv_pkg::NUM_W-1:0]    num_y,
    input  logic [ccpv_pkg::ROOT_W-1:0]   den,
    input  ccpv_pkg::div_tag_t            tag,
    output logic                          done,
    output logic [ccpv_pkg::QUO_W-1:0]    quo_x,
    output logic [ccpv_pkg::QUO_W-1:0]    quo_y,
    output ccpv_pkg::div_tag_t            result_tag
);

    localparam int STEPS = ccpv_pkg::QUO_W;
    localparam int NW    = ccpv_pkg::NUM_W;
    localparam int RW    = ccpv_pkg::DREM_W;
    localparam int DW    = ccpv_pkg::ROOT_W;

    logic [STEPS:0]        valid_reg;
    logic [NW-1:0]         nx_reg  [0:STEPS];
    logic [NW-1:0]         ny_reg  [0:STEPS];
    logic [DW-1:0]         den_reg [0:STEPS];
    logic [RW-1:0]         rx_reg  [0:STEPS];
    logic [RW-1:0]         ry_reg  [0:STEPS];
    logic [STEPS-1:0]      qx_reg  [0:STEPS];
    logic [STEPS-1:0]      qy_reg  [0:STEPS];
    ccpv_pkg::div_tag_t    tag_reg [0:STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[STEPS-1:0], load};
        end
    end

    // high part of the numerator is below the divisor for every real hit
    always_ff @(posedge clk)
    begin
        nx_reg[0]  <= num_x;
        ny_reg[0]  <= num_y;
        den_reg[0] <= den;
        rx_reg[0]  <= RW'(num_x[NW-1:STEPS]);
        ry_reg[0]  <= RW'(num_y[NW-1:STEPS]);
        qx_reg[0]  <= '0;
        qy_reg[0]  <= '0;
        tag_reg[0] <= tag;
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [RW:0]   acc_x;
        logic [RW:0]   acc_y;
        logic [RW:0]   dvs;
        logic          ge_x;
        logic          ge_y;
        logic [RW-1:0] rx_next;
        logic [RW-1:0] ry_next;
        logic [RW:0]   dx;
        logic [RW:0]   dy;

        always_comb
        begin
            acc_x   = {rx_reg[k], nx_reg[k][STEPS-1-k]};
            acc_y   = {ry_reg[k], ny_reg[k][STEPS-1-k]};
            dvs     = {1'b0, den_reg[k]};
            ge_x    = acc_x >= dvs;
            ge_y    = acc_y >= dvs;
            dx      = acc_x - dvs;
            dy      = acc_y - dvs;
            rx_next = ge_x ? dx[RW-1:0] : acc_x[RW-1:0];
            ry_next = ge_y ? dy[RW-1:0] : acc_y[RW-1:0];
        end

        always_ff @(posedge clk)
        begin
            nx_reg[k+1]  <= nx_reg[k];
            ny_reg[k+1]  <= ny_reg[k];
            den_reg[k+1] <= den_reg[k];
            rx_reg[k+1]  <= rx_next;
            ry_reg[k+1]  <= ry_next;
            qx_reg[k+1]  <= {qx_reg[k][STEPS-2:0], ge_x};
            qy_reg[k+1]  <= {qy_reg[k][STEPS-2:0], ge_y};
            tag_reg[k+1] <= tag_reg[k];
        end
    end

    assign done       = valid_reg[STEPS];
    assign quo_x      = qx_reg[STEPS];
    assign quo_y      = qy_reg[STEPS];
    assign result_tag = tag_reg[STEPS];

endmodule

// ===== hdl/circle_collision_push_vector.sv =====
// ---------------------------------------------------------------------------
// circle_collision_push_vector
// Circle against box or circle overlap test with push vector output.
// ---------------------------------------------------------------------------
// A transaction is taken in every cycle that start is high; busy never rises.
// Each result appears on result for one cycle, flagged by done, in order.
// Between a transaction and its result lie the input and square stages,
// a 30-stage square root pipeline (an input register, then one root bit per
// stage), the depth and numerator multiply stages, a 28-stage divider
// pipeline (an input register, then one quotient bit per stage) and the
// output register. The receiver must take every result as it is shown.
module circle_collision_push_vector (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ccpv_pkg::item_t     item,
    output logic                done,
    output ccpv_pkg::result_t   result
);

    `include "assert_macros.svh"

    localparam int CW  = ccpv_pkg::COORD_W;
    localparam int FB  = ccpv_pkg::FRAC_BITS;
    localparam int OW  = ccpv_pkg::OFS_W;
    localparam int RDW = ccpv_pkg::RAD_W;
    localparam int LW  = ccpv_pkg::DIR_W;
    localparam int SW  = ccpv_pkg::SQ_W;
    localparam int L2W = ccpv_pkg::L2_W;
    localparam int PW  = ccpv_pkg::OP_W;
    localparam int MW  = ccpv_pkg::ROOT_W;
    localparam int DPW = ccpv_pkg::DEP_W;
    localparam int PRW = ccpv_pkg::PROD_W;
    localparam int NW  = ccpv_pkg::NUM_W;
    localparam int QW  = ccpv_pkg::QUO_W;
    localparam int DSW = MW - FB;
    localparam int DRW = RDW - FB;

    localparam logic [QW-1:0] POS_MAX = QW'((1 << (CW - 1)) - 1);
    localparam logic [QW-1:0] NEG_MAX = QW'(1 << (CW - 1));

    function automatic logic signed [CW-1:0] sat_push(input logic [QW-1:0] q,
                                                     input logic neg);
        logic [QW-1:0] mag;
        if (neg)
        begin
            mag = (q > NEG_MAX) ? NEG_MAX : q;
            return -$signed(mag[CW-1:0]);
        end
        else
        begin
            mag = (q > POS_MAX) ? POS_MAX : q;
            return $signed(mag[CW-1:0]);
        end
    endfunction

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ---------------- stage 1: clamp and offsets ----------------
    logic signed [CW-1:0] tx, ty;
    logic signed [OW-1:0] rdx, rdy, cdx, cdy, mx, my, wx, wy;
    logic signed [OW-1:0] ox_next, oy_next, sum_next;

    always_comb
    begin
        if (item.circle_x < item.shape_a)
            tx = item.shape_a;
        else if (item.circle_x > item.shape_c)
            tx = item.shape_c;
        else
            tx = item.circle_x;
        if (item.circle_y < item.shape_b)
            ty = item.shape_b;
        else if (item.circle_y > item.shape_d)
            ty = item.shape_d;
        else
            ty = item.circle_y;
        rdx = OW'(item.circle_x) - OW'(tx);
        rdy = OW'(item.circle_y) - OW'(ty);
        cdx = OW'(item.circle_x) - OW'(item.shape_a);
        cdy = OW'(item.circle_y) - OW'(item.shape_b);
        // truncate toward zero to whole units
        mx = rdx[OW-1] ? -rdx : rdx;
        my = rdy[OW-1] ? -rdy : rdy;
        wx = $signed($unsigned(mx) >> FB);
        wy = $signed($unsigned(my) >> FB);
        ox_next  = item.func ? cdx : (rdx[OW-1] ? -wx : wx);
        oy_next  = item.func ? cdy : (rdy[OW-1] ? -wy : wy);
        sum_next = $signed({2'b00, item.circle_radius}) + OW'(item.shape_c);
    end

    logic                 s1_valid_reg;
    logic                 s1_func_reg;
    logic [RDW-1:0]       s1_rad_reg;
    logic signed [OW-1:0] s1_ox_reg, s1_oy_reg, s1_sum_reg;
    logic signed [LW-1:0] s1_lx_reg, s1_ly_reg;

    // ---------------- stage 2: squares ----------------
    logic                 s2_valid_reg;
    logic                 s2_func_reg;
    logic [RDW-1:0]       s2_rad_reg;
    logic signed [OW-1:0] s2_ox_reg, s2_oy_reg, s2_sum_reg;
    logic signed [LW-1:0] s2_lx_reg, s2_ly_reg;
    logic [SW-1:0]        s2_oxx_reg, s2_oyy_reg, s2_ss_reg;
    logic [L2W-1:0]       s2_lxx_reg, s2_lyy_reg;
    logic signed [SW-1:0] oxx_next, oyy_next, ss_next;
    logic signed [L2W-1:0] lxx_next, lyy_next;

    assign oxx_next = s1_ox_reg * s1_ox_reg;
    assign oyy_next = s1_oy_reg * s1_oy_reg;
    assign ss_next  = s1_sum_reg * s1_sum_reg;
    assign lxx_next = s1_lx_reg * s1_lx_reg;
    assign lyy_next = s1_ly_reg * s1_ly_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_func_reg <= item.func;
        s1_rad_reg  <= item.circle_radius;
        s1_ox_reg   <= ox_next;
        s1_oy_reg   <= oy_next;
        s1_sum_reg  <= sum_next;
        s1_lx_reg   <= item.last_dir_x;
        s1_ly_reg   <= item.last_dir_y;

        s2_func_reg <= s1_func_reg;
        s2_rad_reg  <= s1_rad_reg;
        s2_ox_reg   <= s1_ox_reg;
        s2_oy_reg   <= s1_oy_reg;
        s2_sum_reg  <= s1_sum_reg;
        s2_lx_reg   <= s1_lx_reg;
        s2_ly_reg   <= s1_ly_reg;
        s2_oxx_reg  <= $unsigned(oxx_next);
        s2_oyy_reg  <= $unsigned(oyy_next);
        s2_ss_reg   <= $unsigned(ss_next);
        s2_lxx_reg  <= $unsigned(lxx_next);
        s2_lyy_reg  <= $unsigned(lyy_next);
    end

    // ---------------- stage 3: sums, square root operand ----------------
    logic [SW-1:0]       sq;
    logic [L2W-1:0]      l2;
    logic [PW-1:0]       sqrt_op;
    ccpv_pkg::sqrt_tag_t sqrt_tag;

    always_comb
    begin
        sq = s2_oxx_reg + s2_oyy_reg;
        l2 = s2_lxx_reg + s2_lyy_reg;
        sqrt_tag.func = s2_func_reg;
        sqrt_tag.rad  = s2_rad_reg;
        sqrt_tag.ox   = s2_ox_reg;
        sqrt_tag.oy   = s2_oy_reg;
        sqrt_tag.lx   = s2_lx_reg;
        sqrt_tag.ly   = s2_ly_reg;
        sqrt_tag.sum  = s2_sum_reg;
        sqrt_tag.zero = (sq == '0);
        sqrt_tag.chit = (sq <= s2_ss_reg);
        // box mode: root of sq*65536 gives both the whole distance and the
        // normalising length; zero distance falls back to the last direction
        if (s2_func_reg)
            sqrt_op = {sq, 8'b0};
        else if (sq == '0)
            sqrt_op = {10'b0, l2, 16'b0};
        else
            sqrt_op = {sq[PW-17:0], 16'b0};
    end

    logic                sq_done;
    logic [MW-1:0]       m;
    ccpv_pkg::sqrt_tag_t mt;

    ccpv_sqrt u_sqrt (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (s2_valid_reg),
        .operand    (sqrt_op),
        .tag        (sqrt_tag),
        .done       (sq_done),
        .root       (m),
        .result_tag (mt)
    );

    // ---------------- stage D: hit and depth ----------------
    logic [DSW-1:0]        dist_whole;
    logic                  rhit, hit_next, zpush_next;
    logic [DRW-1:0]        depth_r;
    logic signed [DPW-1:0] depth_c, b_next;
    logic signed [OW-1:0]  ax_next, ay_next;

    always_comb
    begin
        dist_whole = mt.zero ? '0 : m[MW-1:FB];
        rhit    = {dist_whole, 8'b0} < MW'(mt.rad);
        depth_r = mt.rad[RDW-1:FB] - dist_whole[DRW-1:0];
        // radius sum may be negative
        depth_c = DPW'($signed({mt.sum, 4'b0})) - $signed({2'b00, m});
        hit_next   = mt.func ? mt.chit : rhit;
        zpush_next = !hit_next || (m == '0);
        if (mt.func)
        begin
            ax_next = mt.ox;
            ay_next = mt.oy;
            b_next  = depth_c;
        end
        else if (mt.zero)
        begin
            ax_next = OW'(mt.lx);
            ay_next = OW'(mt.ly);
            b_next  = DPW'(1);
        end
        else
        begin
            ax_next = mt.ox;
            ay_next = mt.oy;
            b_next  = $signed(DPW'(depth_r));
        end
    end

    logic                  d_valid_reg, d_hit_reg, d_zpush_reg, d_shift_reg;
    logic signed [OW-1:0]  d_ax_reg, d_ay_reg;
    logic signed [DPW-1:0] d_b_reg;
    logic [MW-1:0]         d_m_reg;

    // ---------------- stage E: numerator products ----------------
    logic                  e_valid_reg, e_hit_reg, e_zpush_reg, e_shift_reg;
    logic signed [PRW-1:0] e_px_reg, e_py_reg;
    logic [MW-1:0]         e_m_reg;
    logic signed [PRW-1:0] px_next, py_next;

    assign px_next = d_ax_reg * d_b_reg;
    assign py_next = d_ay_reg * d_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= sq_done;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_hit_reg   <= hit_next;
        d_zpush_reg <= zpush_next;
        d_shift_reg <= !mt.func;
        d_ax_reg    <= ax_next;
        d_ay_reg    <= ay_next;
        d_b_reg     <= b_next;
        d_m_reg     <= m;

        e_hit_reg   <= d_hit_reg;
        e_zpush_reg <= d_zpush_reg;
        e_shift_reg <= d_shift_reg;
        e_px_reg    <= px_next;
        e_py_reg    <= py_next;
        e_m_reg     <= d_m_reg;
    end

    // ---------------- stage F: magnitude plus half divisor ----------------
    logic signed [PRW-1:0] shx, shy;
    logic [PRW-1:0]        magx, magy, half, nx_full, ny_full;
    ccpv_pkg::div_tag_t    div_tag;

    always_comb
    begin
        shx  = e_shift_reg ? {e_px_reg[PRW-17:0], 16'b0} : e_px_reg;
        shy  = e_shift_reg ? {e_py_reg[PRW-17:0], 16'b0} : e_py_reg;
        magx = shx[PRW-1] ? $unsigned(-shx) : $unsigned(shx);
        magy = shy[PRW-1] ? $unsigned(-shy) : $unsigned(shy);
        half = PRW'(e_m_reg >> 1);
        nx_full = magx + half;
        ny_full = magy + half;
        div_tag.hit   = e_hit_reg;
        div_tag.zpush = e_zpush_reg;
        div_tag.neg_x = shx[PRW-1];
        div_tag.neg_y = shy[PRW-1];
    end

    logic               dv_done;
    logic [QW-1:0]      qx, qy;
    ccpv_pkg::div_tag_t qt;

    ccpv_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (e_valid_reg),
        .num_x      (nx_full[NW-1:0]),
        .num_y      (ny_full[NW-1:0]),
        .den        (e_m_reg),
        .tag        (div_tag),
        .done       (dv_done),
        .quo_x      (qx),
        .quo_y      (qy),
        .result_tag (qt)
    );

    // ---------------- output register ----------------
    logic              done_reg;
    ccpv_pkg::result_t result_reg, result_next;

    always_comb
    begin
        result_next.hit    = qt.hit;
        result_next.push_x = qt.zpush ? '0 : sat_push(qx, qt.neg_x);
        result_next.push_y = qt.zpush ? '0 : sat_push(qy, qt.neg_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_done;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // ---------------- checks ----------------
    `ASSERT_IMPLIES(a_result_latency, clk, rst_n, done, $past(start && !busy, ccpv_pkg::LATENCY), "result without a matching transaction")
    `ASSERT_IMPLIES(a_miss_no_push, clk, rst_n, done && !result.hit, result.push_x == '0 && result.push_y == '0, "push vector given without a hit")

endmodule
